// ===== hdl/pmfw_pkg.sv =====
// shared constants, command codes and request/result types for the frame store writer
package pmfw_pkg;

	localparam int PANEL_WIDTH   = 400;
	localparam int PANEL_HEIGHT  = 300;
	localparam int ROWS_OF_TILES = (PANEL_HEIGHT + 3) / 4;
	localparam int COLUMN_PAIRS  = (PANEL_WIDTH + 1) / 2;
	localparam int FRAME_BYTES   = COLUMN_PAIRS * ROWS_OF_TILES;
	localparam int ADDR_W        = $clog2(FRAME_BYTES);

	localparam logic [15:0] BLACK_LIMIT = 16'h7FFF;

	typedef enum logic [1:0] {
		CMD_MONO = 2'd0,
		CMD_RGB  = 2'd1,
		CMD_FILL = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic        black_pixel;
		logic [15:0] rgb_value;
		logic [7:0]  fill_byte;
		logic [13:0] read_index;
	} req_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [13:0] byte_index;
		logic        read_valid;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic pix_rd;
		logic pix_wr;
		logic fill_wr;
		logic rd_req;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t in_cmd;
		logic pix_ok;
		logic rd_ok;
		logic fill_last;
	} dp_status_t;

endpackage

// ===== hdl/pmfw_ram.sv =====
// generic simple dual-port ram with registered read
module pmfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/pmfw_ctrl.sv =====
// command sequencer for pixel, fill and read requests
module pmfw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pmfw_pkg::dp_status_t status,
	output pmfw_pkg::dp_cmd_t   cmd,
	output logic                busy,
	output logic                done
);
	import pmfw_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_FILL,
		ST_RD_REQ,
		ST_RD_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (status.in_cmd)
							CMD_MONO, CMD_RGB: state_q <= ST_PIX_RD;
							CMD_FILL:          state_q <= ST_FILL;
							CMD_READ:          state_q <= ST_RD_REQ;
							default:           state_q <= ST_IDLE;
						endcase
					end
				end
				ST_PIX_RD: state_q <= status.pix_ok ? ST_PIX_WR : ST_IDLE;
				ST_PIX_WR: state_q <= ST_IDLE;
				ST_FILL: begin
					if (status.fill_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_REQ: state_q <= ST_RD_OUT;
				ST_RD_OUT: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.pix_rd  = (state_q == ST_PIX_RD) && status.pix_ok;
		cmd.pix_wr  = (state_q == ST_PIX_WR);
		cmd.fill_wr = (state_q == ST_FILL);
		cmd.rd_req  = (state_q == ST_RD_REQ) && status.rd_ok;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RD_OUT);

endmodule

// ===== hdl/pmfw_dp.sv =====
// address mapping, read-modify-write and fill sweep around the frame store
module pmfw_dp (
	input  logic                 clk,
	input  pmfw_pkg::req_t       req,
	input  pmfw_pkg::dp_cmd_t    cmd,
	output pmfw_pkg::dp_status_t status,
	output pmfw_pkg::result_t    result
);
	import pmfw_pkg::*;

	logic [9:0]        inv_y;
	logic              in_range;
	logic [ADDR_W-1:0] pos;
	logic [7:0]        mask;
	logic              black;

	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        mask_q;
	logic              black_q;
	logic              pix_ok_q;
	logic [7:0]        fill_byte_q;
	logic [13:0]       index_q;
	logic              rd_ok_q;
	logic [ADDR_W-1:0] fill_cnt_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic [7:0]        modified;

	// y counts from the bottom, tiles run column-pair-major
	always_comb begin
		in_range = (32'(req.pixel_x) < PANEL_WIDTH) && (32'(req.pixel_y) < PANEL_HEIGHT);
		inv_y    = 10'(PANEL_HEIGHT - 1) - req.pixel_y;
		pos      = ADDR_W'(32'(req.pixel_x[9:1]) * ROWS_OF_TILES + 32'(inv_y[9:2]));
		mask     = 8'h80 >> {inv_y[1:0], req.pixel_x[0]};
		black    = (req.cmd == CMD_MONO) ? req.black_pixel : (req.rgb_value < BLACK_LIMIT);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q      <= pos;
			mask_q      <= mask;
			black_q     <= black;
			pix_ok_q    <= in_range;
			fill_byte_q <= req.fill_byte;
			index_q     <= req.read_index;
			rd_ok_q     <= 32'(req.read_index) < FRAME_BYTES;
			fill_cnt_q  <= '0;
		end else if (cmd.fill_wr) begin
			fill_cnt_q  <= fill_cnt_q + 1'b1;
		end
	end

	assign modified  = black_q ? (ram_rdata & ~mask_q) : (ram_rdata | mask_q);
	assign ram_we    = cmd.pix_wr || cmd.fill_wr;
	assign ram_waddr = cmd.pix_wr ? addr_q : fill_cnt_q;
	assign ram_wdata = cmd.pix_wr ? modified : fill_byte_q;
	assign ram_re    = cmd.pix_rd || cmd.rd_req;
	assign ram_raddr = cmd.pix_rd ? addr_q : ADDR_W'(index_q);

	pmfw_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign status.in_cmd    = req.cmd;
	assign status.pix_ok    = pix_ok_q;
	assign status.rd_ok     = rd_ok_q;
	assign status.fill_last = (fill_cnt_q == ADDR_W'(FRAME_BYTES - 1));

	assign result.frame_byte = rd_ok_q ? ram_rdata : 8'h00;
	assign result.byte_index = index_q;
	assign result.read_valid = rd_ok_q;

endmodule

// ===== hdl/packed_mono_framebuffer_writer.sv =====
// top level of the packed one-bit-per-pixel frame store writer
//
//   channel   handshake         payload    notes
//   request   start / busy      req        taken when start is high and busy is low
//   result    done (strobe)     result     one cycle per read, cannot be held off
//
// every request occupies the block through the steps below, set by the
// registered-read read-modify-write on the frame store ram and by the fill sweep:
//   pixel write in range: accept, ram read, ram write back
//   pixel write out of range: accept, then a step with no ram access
//   read byte: accept, ram read, done high in the cycle after the ram read
//   fill: accept, then one store entry written per cycle, FRAME_BYTES in all
// arst_n clears only the sequencer; the store holds garbage until the first fill
// the result side has no stall, so a read result is simply presented and dropped
module packed_mono_framebuffer_writer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pmfw_pkg::req_t    req,
	output logic              done,
	output pmfw_pkg::result_t result
);
	import pmfw_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// sequencer: decides which ram access happens each cycle
	pmfw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(dp_status),
		.cmd   (dp_cmd),
		.busy  (busy),
		.done  (done)
	);

	// datapath: pixel-to-byte mapping, bit update, fill counter, store ram
	pmfw_dp u_dp (
		.clk   (clk),
		.req   (req),
		.cmd   (dp_cmd),
		.status(dp_status),
		.result(result)
	);

endmodule

// ===== bench/packed_mono_framebuffer_writer_tb.sv =====
// self-checking testbench for the packed one-bit-per-pixel frame store writer
`timescale 1ns / 100ps

// holds a private copy of the frame image and the read answers still owed by the block
class frame_scoreboard;
	logic [7:0] frame_image [pmfw_pkg::FRAME_BYTES];
	pmfw_pkg::result_t awaited_reads [$];
	int mismatches = 0;

	// byte that holds a pixel, or -1 when the pixel lies off the panel
	function int pixel_pos(int px, int py);
		int inv_y;
		if (px >= pmfw_pkg::PANEL_WIDTH || py >= pmfw_pkg::PANEL_HEIGHT) return -1;
		inv_y = pmfw_pkg::PANEL_HEIGHT - 1 - py;
		return (px / 2) * pmfw_pkg::ROWS_OF_TILES + inv_y / 4;
	endfunction

	function void paint(int px, int py, bit black);
		int pos;
		int inv_y;
		int bit_no;
		pos = pixel_pos(px, py);
		if (pos < 0 || pos >= pmfw_pkg::FRAME_BYTES) return;
		inv_y = pmfw_pkg::PANEL_HEIGHT - 1 - py;
		bit_no = 7 - (((inv_y % 4) * 2) + (px % 2));
		frame_image[pos][bit_no] = !black;
	endfunction

	function void note_request(pmfw_pkg::req_t r);
		pmfw_pkg::result_t answer;
		case (r.cmd)
			pmfw_pkg::CMD_MONO: paint(int'(r.pixel_x), int'(r.pixel_y), r.black_pixel);
			pmfw_pkg::CMD_RGB: paint(int'(r.pixel_x), int'(r.pixel_y),
				r.rgb_value < pmfw_pkg::BLACK_LIMIT);
			pmfw_pkg::CMD_FILL: foreach (frame_image[i]) frame_image[i] = r.fill_byte;
			default: begin
				answer.byte_index = r.read_index;
				answer.read_valid = (r.read_index < pmfw_pkg::FRAME_BYTES);
				answer.frame_byte = answer.read_valid ? frame_image[r.read_index] : 8'h00;
				awaited_reads.push_back(answer);
			end
		endcase
	endfunction

	task report(string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task check_read(pmfw_pkg::result_t got);
		pmfw_pkg::result_t want;
		if (awaited_reads.size() == 0) begin
			report($sformatf("read result with none pending, index %0d", got.byte_index));
			return;
		end
		want = awaited_reads.pop_front();
		if (got.frame_byte !== want.frame_byte)
			report($sformatf("index %0d frame_byte %h, want %h",
				want.byte_index, got.frame_byte, want.frame_byte));
		if (got.byte_index !== want.byte_index)
			report($sformatf("byte_index %0d, want %0d", got.byte_index, want.byte_index));
		if (got.read_valid !== want.read_valid)
			report($sformatf("index %0d read_valid %b, want %b",
				want.byte_index, got.read_valid, want.read_valid));
	endtask

	function int pending();
		return awaited_reads.size();
	endfunction
endclass

module packed_mono_framebuffer_writer_tb;
	import pmfw_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	req_t    req = '0;
	logic    busy;
	logic    done;
	result_t result;

	frame_scoreboard sb = new();

	// pixel byte most recently written in range, so reads can land on live data
	int last_pos = 0;
	// random fills are costly (one pass over the store), so only a few are allowed
	int fills_left = 8;
	// percent of requests followed by a sender gap, one entry per phase
	int gap_pct [4] = '{0, 80, 0, 28};

	packed_mono_framebuffer_writer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// request side: a request is taken at an edge with start high and busy low
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_request(req);
	end

	// result side: the strobe lasts one cycle and cannot be held off
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_read(result);
	end

	// hold the request until the block takes it
	task automatic issue(input req_t r);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender holds off until every read answer is back and the block is idle
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0 || busy !== 1'b0);
	endtask

	// fields a command does not use are left random
	function automatic req_t noise_req();
		req_t r;
		r.cmd         = cmd_t'($urandom_range(0, 3));
		r.pixel_x     = 10'($urandom_range(0, 1023));
		r.pixel_y     = 10'($urandom_range(0, 1023));
		r.black_pixel = 1'($urandom_range(0, 1));
		r.rgb_value   = 16'($urandom_range(0, 16'hFFFF));
		r.fill_byte   = 8'($urandom_range(0, 255));
		r.read_index  = 14'($urandom_range(0, 16383));
		return r;
	endfunction

	function automatic req_t pixel_req(cmd_t c, int x, int y, bit black, logic [15:0] rgb);
		req_t r;
		r             = noise_req();
		r.cmd         = c;
		r.pixel_x     = 10'(x);
		r.pixel_y     = 10'(y);
		r.black_pixel = black;
		r.rgb_value   = rgb;
		return r;
	endfunction

	function automatic req_t read_req(int idx);
		req_t r;
		r            = noise_req();
		r.cmd        = CMD_READ;
		r.read_index = 14'(idx);
		return r;
	endfunction

	function automatic req_t fill_req(logic [7:0] value);
		req_t r;
		r           = noise_req();
		r.cmd       = CMD_FILL;
		r.fill_byte = value;
		return r;
	endfunction

	// one random request, mostly in-range pixel traffic and reads of live bytes
	function automatic req_t random_req();
		req_t r;
		int   roll;
		int   pick;
		r    = noise_req();
		roll = $urandom_range(0, 999);
		pick = $urandom_range(0, 99);
		if (roll < 4 && fills_left > 0) begin
			r.cmd = CMD_FILL;
			fills_left--;
		end else if (roll < 640) begin
			r.cmd = (roll < 380) ? CMD_MONO : CMD_RGB;
			// most writes land on the panel, the rest probe the clipping
			if (pick < 88) begin
				r.pixel_x = 10'($urandom_range(0, PANEL_WIDTH - 1));
				r.pixel_y = 10'($urandom_range(0, PANEL_HEIGHT - 1));
			end else if (pick < 94) begin
				r.pixel_x = 10'($urandom_range(PANEL_WIDTH, 1023));
			end else begin
				r.pixel_y = 10'($urandom_range(PANEL_HEIGHT, 1023));
			end
			// keep the black threshold busy for rgb writes
			if ($urandom_range(0, 2) == 0)
				r.rgb_value = 16'(32'h7FFD + $urandom_range(0, 4));
			if (sb.pixel_pos(int'(r.pixel_x), int'(r.pixel_y)) >= 0)
				last_pos = sb.pixel_pos(int'(r.pixel_x), int'(r.pixel_y));
		end else begin
			r.cmd = CMD_READ;
			if (pick < 55)
				r.read_index = 14'($urandom_range(0, FRAME_BYTES - 1));
			else if (pick < 85)
				r.read_index = 14'(last_pos);
			else if (pick < 95)
				r.read_index = 14'($urandom_range(FRAME_BYTES - 10, 16383));
			// otherwise the noise index stands, over the full field
		end
		return r;
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a pixel write before the first fill is legal, the fill wipes it
		issue(pixel_req(CMD_MONO, 5, 7, 1'b0, 16'h0000));
		issue(fill_req(8'h00));
		// bottom-left of the panel is tile 74 (last tile of the first column pair)
		issue(pixel_req(CMD_MONO, 0, 0, 1'b0, 16'h0000));
		issue(read_req(74));
		// opposite corner: last column pair, first tile row
		issue(pixel_req(CMD_MONO, 399, 299, 1'b0, 16'h0000));
		issue(read_req(14925));
		// rgb just below the threshold is black, at the threshold is white
		issue(pixel_req(CMD_RGB, 399, 299, 1'b0, 16'h7FFE));
		issue(read_req(14925));
		issue(pixel_req(CMD_RGB, 1, 0, 1'b1, 16'h7FFF));
		issue(read_req(74));
		// writes off the panel are dropped
		issue(pixel_req(CMD_MONO, 400, 0, 1'b0, 16'h0000));
		issue(pixel_req(CMD_MONO, 0, 300, 1'b0, 16'h0000));
		issue(pixel_req(CMD_RGB, 1023, 1023, 1'b0, 16'hFFFF));
		issue(read_req(0));
		// last valid byte, first invalid byte, top of the index field
		issue(read_req(FRAME_BYTES - 1));
		issue(read_req(FRAME_BYTES));
		issue(read_req(16383));
		issue(fill_req(8'hFF));
		issue(read_req(0));
		issue(pixel_req(CMD_MONO, 0, 299, 1'b1, 16'hFFFF));
		issue(read_req(0));
		issue(pixel_req(CMD_RGB, 0, 299, 1'b1, 16'hFFFF));
		issue(read_req(0));
		issue(pixel_req(CMD_RGB, 1, 296, 1'b0, 16'h0000));
		issue(read_req(0));
		drain();

		// random phases, with a full drain between them
		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < 500; n++) begin
				issue(random_req());
				if ($urandom_range(1, 100) <= gap_pct[phase])
					pause($urandom_range(1, 4));
			end
			drain();
		end

		// let any stray strobe show up before the verdict
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d read results never arrived", sb.pending()));
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog, well past the slowest legal run including every fill pass
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== packed_mono_framebuffer_writer.f =====
hdl/pmfw_pkg.sv
hdl/pmfw_ram.sv
hdl/pmfw_ctrl.sv
hdl/pmfw_dp.sv
hdl/packed_mono_framebuffer_writer.sv
bench/packed_mono_framebuffer_writer_tb.sv
